// ===== sv/ray_sphere_intersection_assert.svh =====
// Assertion macros for the ray/sphere intersection pipeline.
// Used by ray_sphere_intersection.sv; they expect aclk and aresetn in scope.
`ifndef RAY_SPHERE_INTERSECTION_ASSERT_SVH
`define RAY_SPHERE_INTERSECTION_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define RSI_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rsi_pkg.sv =====
// Types, widths and helpers for the ray/sphere intersection pipeline.
// No dependencies; imported by ray_sphere_intersection.sv.
package rsi_pkg;

    localparam int W    = 24;          // field width
    localparam int IN_W = 6 * W;       // packed input beat
    localparam int OUT_W = 7 * W;      // packed result beat
    localparam int LW   = 25;          // origin minus center
    localparam int AW   = 48;          // D.D, unsigned
    localparam int HW   = 52;          // D.L and L.L - r^2, signed
    localparam int PW   = 104;         // discriminant
    localparam int SW   = 52;          // square root bits
    localparam int QW   = 54;          // stable-form q, signed
    localparam int DMW  = 53;          // divider operand magnitude
    localparam int TQB  = 41;          // quotient bits kept
    localparam int TW   = 42;          // root t, signed

    localparam logic [TQB-1:0] ROOT_LIM = TQB'(1) << 40;

    localparam logic signed [63:0] W_MAX64 = 64'sd8388607;
    localparam logic signed [63:0] W_MIN64 = -64'sd8388608;

    typedef struct packed {
        logic [2:0][W-1:0] o;
        logic [2:0][W-1:0] d;
    } ray_t;

    typedef struct packed {
        ray_t                  ray;
        logic [AW-1:0]         a;
        logic signed [HW-1:0]  h;
        logic signed [HW-1:0]  c;
        logic                  miss;
    } sq_side_t;

    typedef struct packed {
        ray_t ray;
        logic miss;
        logic tang;
    } dv_side_t;

    // clamp to the signed 24-bit range
    function automatic logic signed [W-1:0] sat24(input logic signed [63:0] v);
        logic signed [W-1:0] r;
        if (v > W_MAX64) r = W_MAX64[W-1:0];
        else if (v < W_MIN64) r = W_MIN64[W-1:0];
        else r = v[W-1:0];
        return r;
    endfunction

endpackage

// ===== sv/ray_sphere_intersection.sv =====
// Ray / sphere intersection: fully pipelined quadratic solve, sqrt and two dividers.
// Depends on rsi_pkg and ray_sphere_intersection_assert.svh.
// Pipeline: 52 sqrt stages and 41 divider stages lie between input beat and result beat.
// Throughput: one ray per cycle; the whole pipe holds while a result waits on m_tready.
// Reset: aresetn (synchronous, active low) clears all valid bits; data registers keep values.
`include "ray_sphere_intersection_assert.svh"

module ray_sphere_intersection #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (24 bits each, low first)
    input  logic [rsi_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z (low first)
    output logic [rsi_pkg::OUT_W-1:0]   m_tdata,
    // hit_found
    output logic                        m_tuser
);
    import rsi_pkg::*;

    localparam logic signed [LW-1:0] CENTER = LW'(longint'(1) << (FRAC_BITS - 1));
    localparam longint RADIUS = ((longint'(49) << FRAC_BITS) + 50) / 100;
    localparam logic signed [HW-1:0] RAD_SQ = HW'(RADIUS * RADIUS);
    localparam logic signed [W-1:0] MISS_DIST = (FRAC_BITS >= 23) ? 24'sh800000 :
                                                W'(-(longint'(1) << FRAC_BITS));
    localparam int NUMW = DMW + FRAC_BITS;
    localparam int CW   = NUMW + TQB;

    // global advance: every stage moves when the output slot is free or drained
    logic adv;
    logic m_tvalid_reg;
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;

    // ---------------- stage 1: L = O - center, per-axis products
    logic                    v1_reg;
    ray_t                    r1_reg;
    logic [AW-1:0]           dd1_reg [3];
    logic signed [48:0]      dl1_reg [3];
    logic [48:0]             ll1_reg [3];
    ray_t                    r1_next;
    logic [AW-1:0]           dd1_next [3];
    logic signed [48:0]      dl1_next [3];
    logic [48:0]             ll1_next [3];

    always_comb begin
        logic signed [W-1:0]  de;
        logic signed [LW-1:0] le;
        r1_next.o = s_tdata[0 +: 3 * W];
        r1_next.d = s_tdata[3 * W +: 3 * W];
        for (int i = 0; i < 3; i++) begin
            de = $signed(s_tdata[(3 + i) * W +: W]);
            le = LW'($signed(s_tdata[i * W +: W])) - CENTER;
            dd1_next[i] = AW'(de * de);
            dl1_next[i] = 49'(de * le);
            ll1_next[i] = 49'(le * le);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (adv) v1_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_reg <= r1_next;
            for (int i = 0; i < 3; i++) begin
                dd1_reg[i] <= dd1_next[i];
                dl1_reg[i] <= dl1_next[i];
                ll1_reg[i] <= ll1_next[i];
            end
        end
    end

    // ---------------- stage 2: a, h, c sums
    logic     v2_reg;
    sq_side_t s2_reg;
    sq_side_t s2_next;

    always_comb begin
        s2_next.ray  = r1_reg;
        s2_next.a    = dd1_reg[0] + dd1_reg[1] + dd1_reg[2];
        s2_next.h    = HW'(dl1_reg[0]) + HW'(dl1_reg[1]) + HW'(dl1_reg[2]);
        s2_next.c    = $signed(HW'(ll1_reg[0]) + HW'(ll1_reg[1]) + HW'(ll1_reg[2])) - RAD_SQ;
        s2_next.miss = 1'b0;
        s2_next.miss = (s2_next.a == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (adv) v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) s2_reg <= s2_next;
    end

    // ---------------- stage 3: partial products of h*h and a*|c|
    logic     v3_reg;
    sq_side_t s3_reg;
    logic [51:0] hh3_reg [3];
    logic [51:0] ac3_reg [4];
    logic [51:0] hh3_next [3];
    logic [51:0] ac3_next [4];

    always_comb begin
        logic [HW-1:0] mh, mc, ma;
        mh = s2_reg.h[HW-1] ? HW'(-s2_reg.h) : HW'(s2_reg.h);
        mc = s2_reg.c[HW-1] ? HW'(-s2_reg.c) : HW'(s2_reg.c);
        ma = HW'(s2_reg.a);
        hh3_next[0] = 52'(mh[25:0] * mh[25:0]);
        hh3_next[1] = 52'(mh[25:0] * mh[51:26]);
        hh3_next[2] = 52'(mh[51:26] * mh[51:26]);
        ac3_next[0] = 52'(ma[25:0] * mc[25:0]);
        ac3_next[1] = 52'(ma[25:0] * mc[51:26]);
        ac3_next[2] = 52'(ma[51:26] * mc[25:0]);
        ac3_next[3] = 52'(ma[51:26] * mc[51:26]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (adv) v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_reg <= s2_reg;
            for (int i = 0; i < 3; i++) hh3_reg[i] <= hh3_next[i];
            for (int i = 0; i < 4; i++) ac3_reg[i] <= ac3_next[i];
        end
    end

    // ---------------- stage 4: assemble h^2 and a*|c|
    logic     v4_reg;
    sq_side_t s4_reg;
    logic [PW-1:0] hh4_reg, ac4_reg;
    logic [PW-1:0] hh4_next, ac4_next;

    always_comb begin
        hh4_next = (PW'(hh3_reg[2]) << 52) + (PW'(hh3_reg[1]) << 27) + PW'(hh3_reg[0]);
        ac4_next = (PW'(ac3_reg[3]) << 52) + ((PW'(ac3_reg[1]) + PW'(ac3_reg[2])) << 26)
                 + PW'(ac3_reg[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (adv) v4_reg <= v3_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_reg  <= s3_reg;
            hh4_reg <= hh4_next;
            ac4_reg <= ac4_next;
        end
    end

    // ---------------- stage 5: discriminant, feeds sqrt stage 0
    logic          sq_v_reg    [SW+1];
    logic [SW+1:0] sq_rem_reg  [SW+1];
    logic [SW-1:0] sq_root_reg [SW+1];
    logic [PW-1:0] sq_rad_reg  [SW+1];
    sq_side_t      sq_side_reg [SW+1];
    logic [PW-1:0] disc_next;
    logic          neg_next;
    sq_side_t      side5_next;

    always_comb begin
        neg_next = 1'b0;
        if (s4_reg.c < 0) begin
            disc_next = hh4_reg + ac4_reg;
        end else if (hh4_reg < ac4_reg) begin
            disc_next = hh4_reg;
            neg_next  = 1'b1;
        end else begin
            disc_next = hh4_reg - ac4_reg;
        end
        side5_next      = s4_reg;
        side5_next.miss = s4_reg.miss || neg_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sq_v_reg[0] <= 1'b0;
        else if (adv) sq_v_reg[0] <= v4_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= disc_next;
            sq_side_reg[0] <= side5_next;
        end
    end

    // ---------------- floor square root, one result bit per stage
    for (genvar k = 0; k < SW; k++) begin : g_sq
        localparam int BI = SW - 1 - k;
        logic [SW+1:0] rem_sh, trial;
        logic          ge;

        always_comb begin
            rem_sh = {sq_rem_reg[k][SW-1:0], sq_rad_reg[k][2*BI +: 2]};
            trial  = {sq_root_reg[k], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) sq_v_reg[k+1] <= 1'b0;
            else if (adv) sq_v_reg[k+1] <= sq_v_reg[k];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[k+1]  <= ge ? rem_sh - trial : rem_sh;
                sq_root_reg[k+1] <= {sq_root_reg[k][SW-2:0], ge};
                sq_rad_reg[k+1]  <= sq_rad_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // ---------------- stage 6: stable-form q, divider operands
    logic           v6_reg;
    dv_side_t       s6_reg;
    logic [DMW-1:0] num6_reg [2];
    logic [DMW-1:0] den6_reg [2];
    logic           sgn6_reg [2];
    logic [DMW-1:0] num6_next [2];
    logic [DMW-1:0] den6_next [2];
    logic           sgn6_next [2];
    logic           tang6_next;
    dv_side_t       s6_next;

    always_comb begin
        logic signed [QW-1:0] hq, sq, q, cq;
        sq_side_t sd;
        sd = sq_side_reg[SW];
        hq = QW'(sd.h);
        cq = QW'(sd.c);
        sq = $signed(QW'(sq_root_reg[SW]));
        q  = (hq > 0) ? -(hq + sq) : (sq - hq);
        tang6_next = (sq_rad_reg[SW] == '0);
        // t0 = q / a; in the tangent case s = 0 so q = -h
        num6_next[0] = DMW'(q[QW-1] ? -q : q);
        den6_next[0] = DMW'(sd.a);
        sgn6_next[0] = q[QW-1];
        // t1 = c / q, replaced by t0 when tangent
        num6_next[1] = DMW'(cq[QW-1] ? -cq : cq);
        den6_next[1] = tang6_next ? DMW'(sd.a) : DMW'(q[QW-1] ? -q : q);
        sgn6_next[1] = cq[QW-1] ^ (!tang6_next && q[QW-1]);
        s6_next.ray  = sd.ray;
        s6_next.miss = sd.miss;
        s6_next.tang = tang6_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (adv) v6_reg <= sq_v_reg[SW];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_reg <= s6_next;
            for (int j = 0; j < 2; j++) begin
                num6_reg[j] <= num6_next[j];
                den6_reg[j] <= den6_next[j];
                sgn6_reg[j] <= sgn6_next[j];
            end
        end
    end

    // ---------------- stage 7: overflow precheck, divider stage 0
    logic            dv_v_reg    [TQB+1];
    dv_side_t        dv_side_reg [TQB+1];
    logic [DMW-1:0]  dv_rem_reg  [TQB+1][2];
    logic [NUMW-1:0] dv_num_reg  [TQB+1][2];
    logic [DMW-1:0]  dv_den_reg  [TQB+1][2];
    logic [TQB-1:0]  dv_q_reg    [TQB+1][2];
    logic            dv_ovf_reg  [TQB+1][2];
    logic            dv_sgn_reg  [TQB+1][2];
    logic [NUMW-1:0] nsh7_next [2];
    logic            ovf7_next [2];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            nsh7_next[j] = NUMW'(num6_reg[j]) << FRAC_BITS;
            ovf7_next[j] = (CW'(nsh7_next[j]) >= (CW'(den6_reg[j]) << TQB));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) dv_v_reg[0] <= 1'b0;
        else if (adv) dv_v_reg[0] <= v6_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_side_reg[0] <= s6_reg;
            for (int j = 0; j < 2; j++) begin
                dv_rem_reg[0][j] <= DMW'(nsh7_next[j] >> TQB);
                dv_num_reg[0][j] <= nsh7_next[j];
                dv_den_reg[0][j] <= den6_reg[j];
                dv_q_reg[0][j]   <= '0;
                dv_ovf_reg[0][j] <= ovf7_next[j];
                dv_sgn_reg[0][j] <= sgn6_reg[j];
            end
        end
    end

    // ---------------- restoring dividers, one quotient bit per stage
    for (genvar k = 0; k < TQB; k++) begin : g_dv
        localparam int BI = TQB - 1 - k;
        logic [DMW:0] rem_sh [2];
        logic         ge     [2];

        always_comb begin
            for (int j = 0; j < 2; j++) begin
                rem_sh[j] = {dv_rem_reg[k][j], dv_num_reg[k][j][BI]};
                ge[j]     = (rem_sh[j] >= {1'b0, dv_den_reg[k][j]});
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) dv_v_reg[k+1] <= 1'b0;
            else if (adv) dv_v_reg[k+1] <= dv_v_reg[k];
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_side_reg[k+1] <= dv_side_reg[k];
                for (int j = 0; j < 2; j++) begin
                    dv_rem_reg[k+1][j] <= ge[j] ? DMW'(rem_sh[j] - {1'b0, dv_den_reg[k][j]})
                                                : DMW'(rem_sh[j]);
                    dv_num_reg[k+1][j] <= dv_num_reg[k][j];
                    dv_den_reg[k+1][j] <= dv_den_reg[k][j];
                    dv_q_reg[k+1][j]   <= {dv_q_reg[k][j][TQB-2:0], ge[j]};
                    dv_ovf_reg[k+1][j] <= dv_ovf_reg[k][j];
                    dv_sgn_reg[k+1][j] <= dv_sgn_reg[k][j];
                end
            end
        end
    end

    // ---------------- stage 8: saturate and sign the two roots
    logic                 v8_reg;
    dv_side_t             s8_reg;
    logic signed [TW-1:0] t8_reg [2];
    logic signed [TW-1:0] t8_next [2];

    always_comb begin
        logic [TQB-1:0] qm;
        for (int j = 0; j < 2; j++) begin
            qm = (dv_ovf_reg[TQB][j] || dv_q_reg[TQB][j] > ROOT_LIM) ? ROOT_LIM
                                                                     : dv_q_reg[TQB][j];
            t8_next[j] = dv_sgn_reg[TQB][j] ? -$signed(TW'(qm)) : $signed(TW'(qm));
        end
        if (dv_side_reg[TQB].tang) t8_next[1] = t8_next[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v8_reg <= 1'b0;
        else if (adv) v8_reg <= dv_v_reg[TQB];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s8_reg    <= dv_side_reg[TQB];
            t8_reg[0] <= t8_next[0];
            t8_reg[1] <= t8_next[1];
        end
    end

    // ---------------- stage 9: pick the smallest non-negative root
    logic                v9_reg;
    ray_t                r9_reg;
    logic                hit9_reg;
    logic signed [W-1:0] dist9_reg;
    logic                hit9_next;
    logic signed [W-1:0] dist9_next;

    always_comb begin
        logic signed [TW-1:0] lo, hi, sel;
        lo = (t8_reg[0] > t8_reg[1]) ? t8_reg[1] : t8_reg[0];
        hi = (t8_reg[0] > t8_reg[1]) ? t8_reg[0] : t8_reg[1];
        sel = (lo < 0) ? hi : lo;
        hit9_next  = !s8_reg.miss && !sel[TW-1];
        dist9_next = hit9_next ? sat24(64'(sel)) : MISS_DIST;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v9_reg <= 1'b0;
        else if (adv) v9_reg <= v8_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            r9_reg    <= s8_reg.ray;
            hit9_reg  <= hit9_next;
            dist9_reg <= dist9_next;
        end
    end

    // ---------------- stage 10: D * distance
    logic                v10_reg;
    ray_t                r10_reg;
    logic                hit10_reg;
    logic signed [W-1:0] dist10_reg;
    logic signed [47:0]  prod10_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v10_reg <= 1'b0;
        else if (adv) v10_reg <= v9_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            r10_reg    <= r9_reg;
            hit10_reg  <= hit9_reg;
            dist10_reg <= dist9_reg;
            for (int i = 0; i < 3; i++)
                prod10_reg[i] <= 48'($signed(r9_reg.d[i])) * 48'(dist9_reg);
        end
    end

    // ---------------- stage 11: hit point, floor of the scaled product
    logic                v11_reg;
    logic                hit11_reg;
    logic signed [W-1:0] dist11_reg;
    logic signed [W-1:0] pt11_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) v11_reg <= 1'b0;
        else if (adv) v11_reg <= v10_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit11_reg  <= hit10_reg;
            dist11_reg <= dist10_reg;
            for (int i = 0; i < 3; i++)
                pt11_reg[i] <= sat24(64'($signed(r10_reg.o[i]))
                                     + 64'(prod10_reg[i] >>> FRAC_BITS));
        end
    end

    // ---------------- output register: normal = point - center
    logic                hit_out_reg;
    logic signed [W-1:0] dist_out_reg;
    logic signed [W-1:0] pt_out_reg [3];
    logic signed [W-1:0] nrm_out_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (adv) m_tvalid_reg <= v11_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit_out_reg  <= hit11_reg;
            dist_out_reg <= dist11_reg;
            for (int i = 0; i < 3; i++) begin
                pt_out_reg[i]  <= pt11_reg[i];
                nrm_out_reg[i] <= sat24(64'(pt11_reg[i]) - 64'(CENTER));
            end
        end
    end

    assign m_tuser = hit_out_reg;
    assign m_tdata = {nrm_out_reg[2], nrm_out_reg[1], nrm_out_reg[0],
                      pt_out_reg[2], pt_out_reg[1], pt_out_reg[0], dist_out_reg};

    // ---------------- checks
    `RSI_ASSERT(a_hit_nonneg, m_tvalid && m_tuser, !m_tdata[W-1], "hit with negative distance")
    `RSI_ASSERT(a_miss_dist, m_tvalid && !m_tuser, m_tdata[W-1:0] == MISS_DIST, "miss distance wrong")
    `RSI_ASSERT(a_stall, m_tvalid && !m_tready, !s_tready, "input taken while output stalled")
    `RSI_ASSERT_NEXT(a_drain, adv && v11_reg, m_tvalid, "last stage beat lost")

endmodule
